@@ sv/sel_pkg.sv @@
// ----------------------------------------------------------------------------
// sel_pkg
// Shared codes for the sorted edge list: operation kinds, status codes and
// the per-cycle cell command.
// ----------------------------------------------------------------------------
package sel_pkg;

    localparam int KIND_BITS   = 2;
    localparam int STATUS_BITS = 2;
    localparam int OP_BITS     = 3;

    typedef logic [KIND_BITS-1:0]   t_kind;
    typedef logic [STATUS_BITS-1:0] t_status;
    typedef logic [OP_BITS-1:0]     t_op;

    localparam t_kind KIND_INSERT  = 2'd0;
    localparam t_kind KIND_RM_HEAD = 2'd1;
    localparam t_kind KIND_RM_TAIL = 2'd2;
    localparam t_kind KIND_RM_KEY  = 2'd3;

    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    // cell commands
    localparam t_op OP_IDLE    = 3'd0;
    localparam t_op OP_INSERT  = 3'd1;
    localparam t_op OP_RM_HEAD = 3'd2;
    localparam t_op OP_RM_TAIL = 3'd3;
    localparam t_op OP_RM_KEY  = 3'd4;

endpackage

@@ sv/sel_cell.sv @@
// ----------------------------------------------------------------------------
// sel_cell
// One slot of the sorted chain. Holds one edge, flags weight order and key
// match, and shifts toward the tail on insert or toward the head on removal.
// ----------------------------------------------------------------------------
module sel_cell #(
    parameter int IDX      = 0,
    parameter int CNT_BITS = 5,
    parameter int VB       = 8,
    parameter int WB       = 16
) (
    input  logic                 i_clk,
    input  sel_pkg::t_op         i_op,
    input  logic [CNT_BITS-1:0]  i_count,
    input  logic [VB-1:0]        i_key_src,
    input  logic [VB-1:0]        i_key_dst,
    input  logic signed [WB-1:0] i_key_weight,
    input  logic                 i_le_left,
    input  logic                 i_found_left,
    input  logic [VB-1:0]        i_left_src,
    input  logic [VB-1:0]        i_left_dst,
    input  logic signed [WB-1:0] i_left_weight,
    input  logic [VB-1:0]        i_right_src,
    input  logic [VB-1:0]        i_right_dst,
    input  logic signed [WB-1:0] i_right_weight,
    output logic                 o_le,
    output logic                 o_found,
    output logic                 o_tail_hit,
    output logic [VB-1:0]        o_src,
    output logic [VB-1:0]        o_dst,
    output logic signed [WB-1:0] o_weight
);
    import sel_pkg::*;

    logic [VB-1:0]        r_src, n_src;
    logic [VB-1:0]        r_dst, n_dst;
    logic signed [WB-1:0] r_weight, n_weight;
    logic                 occ;
    logic                 last;
    logic                 hit;
    logic                 shift;

    assign occ  = CNT_BITS'(IDX) < i_count;
    assign last = CNT_BITS'(IDX + 1) == i_count;
    assign hit  = occ && (r_src == i_key_src) && (r_dst == i_key_dst);

    assign o_le       = occ && (r_weight <= i_key_weight);
    assign o_found    = i_found_left | hit;
    assign o_tail_hit = hit & last;

    always_comb begin
        n_src    = r_src;
        n_dst    = r_dst;
        n_weight = r_weight;
        shift    = 1'b0;
        case (i_op)
            OP_RM_HEAD: shift = 1'b1;
            OP_RM_TAIL: shift = last;
            OP_RM_KEY:  shift = o_found;
            default:    shift = 1'b0;
        endcase
        if (i_op == OP_INSERT && !o_le) begin
            if (i_le_left) begin
                n_src    = i_key_src;
                n_dst    = i_key_dst;
                n_weight = i_key_weight;
            end else begin
                n_src    = i_left_src;
                n_dst    = i_left_dst;
                n_weight = i_left_weight;
            end
        end else if (shift) begin
            n_src    = i_right_src;
            n_dst    = i_right_dst;
            n_weight = i_right_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src    <= n_src;
        r_dst    <= n_dst;
        r_weight <= n_weight;
    end

    assign o_src    = r_src;
    assign o_dst    = r_dst;
    assign o_weight = r_weight;

endmodule

@@ sv/sorted_edge_list_top.sv @@
// ----------------------------------------------------------------------------
// sorted_edge_list_top
// Sorted-list priority queue of weighted edges built as a chain of cells.
//
//  channel   signals                                   handshake
//  command   i_kind i_src i_dst i_weight               start & !busy
//  result    o_status o_count o_head_valid o_head_*    o_done, one cycle
//
// The accept edge latches an item and sets busy; while busy, every cell
// updates at once from its neighbors. The result strobes in the cycle after
// that, while the next item may already be accepted. busy is high for the
// one update cycle. The receiver cannot stall. Reset empties the list at once.
// ----------------------------------------------------------------------------
module sorted_edge_list_top #(
    parameter int DEPTH       = 16,
    parameter int VERTEX_BITS = 8,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  sel_pkg::t_kind                        i_kind,
    input  logic [VERTEX_BITS-1:0]                i_src,
    input  logic [VERTEX_BITS-1:0]                i_dst,
    input  logic signed [WEIGHT_BITS-1:0]         i_weight,
    output logic                                  o_done,
    output sel_pkg::t_status                      o_status,
    output logic [$clog2(DEPTH+1)-1:0]            o_count,
    output logic                                  o_head_valid,
    output logic [VERTEX_BITS-1:0]                o_head_src,
    output logic [VERTEX_BITS-1:0]                o_head_dst,
    output logic signed [WEIGHT_BITS-1:0]         o_head_weight
);
    import sel_pkg::*;

    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic                          r_busy, r_done;
    logic [CNT_BITS-1:0]           r_count, n_count;
    t_status                       r_status, n_status;
    t_kind                         r_kind;
    logic [VERTEX_BITS-1:0]        r_src, r_dst;
    logic signed [WEIGHT_BITS-1:0] r_weight;
    t_op                           op;

    logic [VERTEX_BITS-1:0]        c_src [DEPTH];
    logic [VERTEX_BITS-1:0]        c_dst [DEPTH];
    logic signed [WEIGHT_BITS-1:0] c_weight [DEPTH];
    logic [DEPTH-1:0]              c_le, c_found, c_tail_hit;
    logic                          head_hit, tail_hit, any_hit, full, empty;

    assign full     = r_count == CNT_BITS'(DEPTH);
    assign empty    = r_count == '0;
    assign head_hit = c_found[0];
    assign tail_hit = |c_tail_hit;
    assign any_hit  = c_found[DEPTH-1];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic                          le_l, found_l;
            logic [VERTEX_BITS-1:0]        l_src, l_dst, rt_src, rt_dst;
            logic signed [WEIGHT_BITS-1:0] l_weight, rt_weight;
            if (g == 0) begin : g_first
                assign le_l     = 1'b1;
                assign found_l  = 1'b0;
                assign l_src    = r_src;
                assign l_dst    = r_dst;
                assign l_weight = r_weight;
            end else begin : g_mid
                assign le_l     = c_le[g-1];
                assign found_l  = c_found[g-1];
                assign l_src    = c_src[g-1];
                assign l_dst    = c_dst[g-1];
                assign l_weight = c_weight[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign rt_src    = c_src[g];
                assign rt_dst    = c_dst[g];
                assign rt_weight = c_weight[g];
            end else begin : g_inner
                assign rt_src    = c_src[g+1];
                assign rt_dst    = c_dst[g+1];
                assign rt_weight = c_weight[g+1];
            end
            sel_cell #(
                .IDX      (g),
                .CNT_BITS (CNT_BITS),
                .VB       (VERTEX_BITS),
                .WB       (WEIGHT_BITS)
            ) u_cell (
                .i_clk          (i_clk),
                .i_op           (op),
                .i_count        (r_count),
                .i_key_src      (r_src),
                .i_key_dst      (r_dst),
                .i_key_weight   (r_weight),
                .i_le_left      (le_l),
                .i_found_left   (found_l),
                .i_left_src     (l_src),
                .i_left_dst     (l_dst),
                .i_left_weight  (l_weight),
                .i_right_src    (rt_src),
                .i_right_dst    (rt_dst),
                .i_right_weight (rt_weight),
                .o_le           (c_le[g]),
                .o_found        (c_found[g]),
                .o_tail_hit     (c_tail_hit[g]),
                .o_src          (c_src[g]),
                .o_dst          (c_dst[g]),
                .o_weight       (c_weight[g])
            );
        end
    endgenerate

    always_comb begin
        op       = OP_IDLE;
        n_status = ST_DONE;
        n_count  = r_count;
        if (r_busy) begin
            if (r_kind == KIND_INSERT) begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    op      = OP_INSERT;
                    n_count = r_count + CNT_BITS'(1);
                end
            end else if (empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_count = r_count - CNT_BITS'(1);
                unique case (r_kind)
                    KIND_RM_HEAD: op = OP_RM_HEAD;
                    KIND_RM_TAIL: op = OP_RM_TAIL;
                    default: begin
                        if (head_hit) begin
                            op = OP_RM_HEAD;
                        end else if (tail_hit) begin
                            op = OP_RM_TAIL;
                        end else if (any_hit) begin
                            op = OP_RM_KEY;
                        end else begin
                            n_status = ST_EMPTY;
                            n_count  = r_count;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= start & ~r_busy;
            r_done  <= r_busy;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !r_busy) begin
            r_kind   <= i_kind;
            r_src    <= i_src;
            r_dst    <= i_dst;
            r_weight <= i_weight;
        end
        if (r_busy) begin
            r_status <= n_status;
        end
    end

    assign busy          = r_busy;
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_count       = r_count;
    assign o_head_valid  = !empty;
    assign o_head_src    = empty ? '0 : c_src[0];
    assign o_head_dst    = empty ? '0 : c_dst[0];
    assign o_head_weight = empty ? '0 : c_weight[0];

endmodule
